FILE: src/assert_macros.svh
// assertion macros shared by the matcher rtl
// no dependencies; checks compile out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: src/mtlm_pkg.sv
// types, codes and helpers for the media type list matcher
// no dependencies
`timescale 1ns / 1ps
package mtlm_pkg;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_RESP   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_TYPE    = 3'd0,
		ST_SUBTYPE = 3'd1,
		ST_OWS     = 3'd2,
		ST_PARAM   = 3'd3,
		ST_QUOT1   = 3'd4,
		ST_QUOT2   = 3'd5,
		ST_END     = 3'd6
	} parse_t;

	typedef enum logic [1:0] {
		V_OPEN  = 2'd0,
		V_MATCH = 2'd1,
		V_MISS  = 2'd2
	} verdict_t;

	typedef struct packed {
		logic       restart;
		logic       clear;
		logic       step;
		logic [7:0] ch;
	} lane_ctrl_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

FILE: src/mtlm_ram.sv
// generic simple ram: one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps
module mtlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end
endmodule

FILE: src/mtlm_cell.sv
// one matcher cell: holds one pattern in its own ram and walks a response
// depends on mtlm_pkg and mtlm_ram; passes the match chain to its neighbor
`timescale 1ns / 1ps
module mtlm_cell
	import mtlm_pkg::*;
#(
	parameter int MAX_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lane_ctrl_t ctrl,
	input  logic       active,
	input  logic       wr_en,
	input  logic       hit_in,
	output logic       hit_out
);
	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int PW = $clog2(MAX_LEN + 2);

	logic [LW-1:0] len_q;
	logic          slash_q;
	parse_t        st_q, st_n;
	logic [PW-1:0] pos_q, pos_n;
	verdict_t      v_q, v_n;
	logic          hold_q, hold_n;

	logic [AW-1:0] raddr0, raddr1;
	logic [7:0]    rd0, rd1;
	logic [PW-1:0] idx0;
	logic [PW:0]   idx1;
	logic [7:0]    f0, f1, c1, c2;
	logic          chk;

	assign idx0   = hold_q ? pos_q - PW'(1) : pos_q;
	assign idx1   = {1'b0, pos_q} + (PW+1)'(1);
	assign raddr0 = idx0[AW-1:0];
	assign raddr1 = idx1[AW-1:0];

	mtlm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram (
		.clk   (clk),
		.we    (wr_en && len_q < LW'(MAX_LEN)),
		.waddr (len_q[AW-1:0]),
		.wdata (ctrl.ch),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(rd0),
		.rdata1(rd1)
	);

	assign f0 = ({1'b0, idx0} >= (PW+1)'(len_q)) ? CH_NUL : fold(rd0);
	assign f1 = (idx1 >= (PW+1)'(len_q)) ? CH_NUL : fold(rd1);
	assign c1 = fold(ctrl.ch);

	always_comb begin
		st_n   = st_q;
		pos_n  = pos_q;
		v_n    = v_q;
		hold_n = hold_q;
		c2     = f0;
		chk    = 1'b0;
		if (v_q == V_OPEN) begin
			if (slash_q && len_q == LW'(1)) begin
				v_n = V_MATCH;
			end else if (hold_q) begin
				hold_n = 1'b0;
				c2     = (pos_q != '0) ? f0 : CH_NUL;
				chk    = 1'b1;
				case (st_q)
					ST_SUBTYPE: begin
						if (c1 == CH_SEMI && c2 == CH_NUL) begin
							v_n = V_MATCH;
							chk = 1'b0;
						end else begin
							st_n = ST_OWS;
						end
					end
					ST_OWS:   st_n = ST_PARAM;
					ST_PARAM: st_n = ST_QUOT1;
					ST_QUOT1: st_n = ST_END;
					default:  ;
				endcase
			end else begin
				chk   = 1'b1;
				pos_n = (pos_q <= PW'(MAX_LEN)) ? pos_q + PW'(1) : pos_q;
				case (st_q)
					ST_TYPE: begin
						if (c2 == CH_SLASH) st_n = ST_SUBTYPE;
					end
					ST_SUBTYPE: begin
						if (c2 == CH_STAR) begin
							v_n = V_MATCH;
							chk = 1'b0;
						end else if (c1 == CH_SPACE && c1 != c2) begin
							hold_n = 1'b1;
							chk    = 1'b0;
						end else if (c2 == CH_SPACE && c1 != c2) begin
							c2    = f1;
							pos_n = (pos_n <= PW'(MAX_LEN)) ? pos_n + PW'(1) : pos_n;
							st_n  = ST_OWS;
						end else if (c1 == CH_SEMI) begin
							if (c2 == CH_NUL) begin
								v_n = V_MATCH;
								chk = 1'b0;
							end else begin
								st_n = ST_OWS;
							end
						end
					end
					ST_OWS: begin
						if (c1 == CH_SPACE && c1 != c2) begin
							hold_n = 1'b1;
							chk    = 1'b0;
						end else begin
							if (c2 == CH_SPACE && c1 != c2) begin
								c2    = f1;
								pos_n = (pos_n <= PW'(MAX_LEN)) ? pos_n + PW'(1) : pos_n;
							end
							st_n = ST_PARAM;
						end
					end
					ST_PARAM: begin
						if (c1 == CH_QUOTE && c1 != c2) begin
							hold_n = 1'b1;
							chk    = 1'b0;
						end else if (c2 == CH_QUOTE && c1 != c2) begin
							c2    = f1;
							pos_n = (pos_n <= PW'(MAX_LEN)) ? pos_n + PW'(1) : pos_n;
							st_n  = ST_QUOT2;
						end
					end
					ST_QUOT1: begin
						if (c1 == CH_QUOTE && c1 != c2) begin
							hold_n = 1'b1;
							chk    = 1'b0;
						end
					end
					ST_QUOT2: begin
						if (c2 == CH_QUOTE && c1 != c2) begin
							c2    = f1;
							pos_n = (pos_n <= PW'(MAX_LEN)) ? pos_n + PW'(1) : pos_n;
							st_n  = ST_END;
						end
					end
					default: ;
				endcase
			end
			if (chk) begin
				if (c1 == CH_NUL) begin
					v_n = (c2 == CH_NUL) ? V_MATCH : V_MISS;
				end else if (c1 != c2) begin
					v_n = V_MISS;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			slash_q <= 1'b0;
			st_q    <= ST_TYPE;
			pos_q   <= '0;
			v_q     <= V_OPEN;
			hold_q  <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				len_q <= '0;
			end else if (wr_en && len_q < LW'(MAX_LEN)) begin
				len_q <= len_q + LW'(1);
				if (len_q == '0) slash_q <= (ctrl.ch == CH_SLASH);
			end
			if (ctrl.restart) begin
				st_q   <= ST_TYPE;
				pos_q  <= '0;
				v_q    <= V_OPEN;
				hold_q <= 1'b0;
			end else if (ctrl.step && active) begin
				st_q   <= st_n;
				pos_q  <= pos_n;
				v_q    <= v_n;
				hold_q <= hold_n;
			end
		end
	end

	assign hit_out = hit_in | (active && v_q == V_MATCH);
endmodule

FILE: src/media_type_list_matcher.sv
// Media type list matcher: stores up to NUM_PATTERNS patterns (action 1 appends a byte,
// a NUL byte closes a pattern, action 0 clears the list) and matches response bytes
// (action 2) against all of them at once, one matcher cell per pattern. Each cell keeps
// its pattern in a small ram with registered reads, so a response byte is handled as a ram read
// and then a cell update in S_EXEC; the closing NUL then waits in S_FIN to gather the match
// chain into in_list, and stays there while an earlier result has not been taken.
// New bytes are accepted only in S_IDLE; append and clear bytes leave the block idle. No clearing pass is needed.
// depends on mtlm_pkg, mtlm_cell, mtlm_ram and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module media_type_list_matcher
	import mtlm_pkg::*;
#(
	parameter int NUM_PATTERNS    = 8,
	parameter int MAX_PATTERN_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] character,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       in_list
);
	localparam int CW = $clog2(NUM_PATTERNS + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FIN
	} fsm_t;

	fsm_t          state_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    ch_q;
	logic          out_valid_q;
	logic          in_list_q;
	logic          acc;
	logic          fin_fire;
	logic          fin_stall;
	lane_ctrl_t    ctrl;
	logic [NUM_PATTERNS:0] hit;

	assign in_ready  = (state_q == S_IDLE);
	assign acc       = in_valid && in_ready;
	assign fin_fire  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign fin_stall = (state_q == S_FIN) && out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign in_list   = in_list_q;

	always_comb begin
		ctrl.clear   = acc && action == ACT_CLEAR;
		ctrl.restart = (acc && (action == ACT_CLEAR || action == ACT_APPEND)) || fin_fire;
		ctrl.step    = (state_q == S_EXEC);
		ctrl.ch      = (state_q == S_IDLE) ? character : ch_q;
	end

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < NUM_PATTERNS; i++) begin : g_cell
		mtlm_cell #(.MAX_LEN(MAX_PATTERN_LEN)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.active (CW'(i) < cnt_q),
			.wr_en  (acc && action == ACT_APPEND && character != CH_NUL && cnt_q == CW'(i)),
			.hit_in (hit[i]),
			.hit_out(hit[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			in_list_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !fin_fire) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (action)
							ACT_CLEAR: cnt_q <= '0;
							ACT_APPEND: begin
								if (cnt_q < CW'(NUM_PATTERNS) && character == CH_NUL) begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							ACT_RESP: begin
								ch_q    <= character;
								state_q <= S_EXEC;
							end
							default: ;
						endcase
					end
				end
				S_EXEC: begin
					state_q <= (ch_q == CH_NUL) ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (fin_fire) begin
						out_valid_q <= 1'b1;
						in_list_q   <= hit[NUM_PATTERNS];
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > CW'(NUM_PATTERNS))
	`ASSERT_CLK(a_resp_exec, clk, arst_n, (acc && action == ACT_RESP) |=> state_q == S_EXEC)
	`ASSERT_CLK(a_fin_wait, clk, arst_n, fin_stall |=> (state_q == S_FIN && out_valid_q))
endmodule

FILE: tb/tb_media_type_list_matcher.sv
// self-checking testbench for media_type_list_matcher: random and directed pattern lists
// and response strings, with a built-in matcher predictor and random stalls on both sides
// depends on mtlm_pkg and media_type_list_matcher
`timescale 1ns / 1ps
module tb_media_type_list_matcher;
	import mtlm_pkg::*;

	localparam int NPAT = 8;
	localparam int PLEN = 64;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		action_t    act;
		logic [7:0] ch;
	} item_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	logic [7:0] character;
	logic out_valid;
	logic out_ready;
	logic in_list;

	media_type_list_matcher #(.NUM_PATTERNS(NPAT), .MAX_PATTERN_LEN(PLEN)) uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .character(character), .out_valid(out_valid),
		.out_ready(out_ready), .in_list(in_list)
	);

	// predictor state
	logic [7:0] pat_mem [NPAT][PLEN];
	int pat_len [NPAT];
	int pat_cnt;
	parse_t lane_st [NPAT];
	int lane_pos [NPAT];
	verdict_t lane_v [NPAT];
	bit lane_hold [NPAT];

	item_t pending_items[$];
	logic expected_hits[$];
	int errors;
	int idle_cycles;
	bit sender_done;
	bit in_taken;

	function automatic logic [7:0] lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] pat_at(int l, int idx);
		return (idx >= pat_len[l]) ? CH_NUL : lower(pat_mem[l][idx]);
	endfunction

	task automatic restart_lanes();
		for (int i = 0; i < NPAT; i++) begin
			lane_st[i] = ST_TYPE;
			lane_pos[i] = 0;
			lane_v[i] = V_OPEN;
			lane_hold[i] = 0;
		end
	endtask

	function automatic logic [7:0] next_pat(int l);
		logic [7:0] c;
		c = pat_at(l, lane_pos[l]);
		if (lane_pos[l] <= PLEN)
			lane_pos[l]++;
		return c;
	endfunction

	task automatic step_lane(int i, logic [7:0] c1);
		logic [7:0] c2;
		if (lane_v[i] != V_OPEN)
			return;
		if (pat_len[i] == 1 && pat_mem[i][0] == CH_SLASH) begin
			lane_v[i] = V_MATCH;
			return;
		end
		if (lane_hold[i]) begin
			lane_hold[i] = 0;
			c2 = (lane_pos[i] > 0) ? pat_at(i, lane_pos[i] - 1) : CH_NUL;
			case (lane_st[i])
				ST_SUBTYPE: begin
					if (c1 == CH_SEMI && c2 == CH_NUL) begin
						lane_v[i] = V_MATCH;
						return;
					end
					lane_st[i] = ST_OWS;
				end
				ST_OWS: lane_st[i] = ST_PARAM;
				ST_PARAM: lane_st[i] = ST_QUOT1;
				ST_QUOT1: lane_st[i] = ST_END;
				default: ;
			endcase
		end else begin
			c2 = next_pat(i);
			case (lane_st[i])
				ST_TYPE: if (c2 == CH_SLASH) lane_st[i] = ST_SUBTYPE;
				ST_SUBTYPE: begin
					if (c2 == CH_STAR) begin
						lane_v[i] = V_MATCH;
						return;
					end
					if (c1 == CH_SPACE && c1 != c2) begin
						lane_hold[i] = 1;
						return;
					end
					if (c2 == CH_SPACE && c1 != c2) begin
						c2 = next_pat(i);
						lane_st[i] = ST_OWS;
					end else if (c1 == CH_SEMI) begin
						if (c2 == CH_NUL) begin
							lane_v[i] = V_MATCH;
							return;
						end
						lane_st[i] = ST_OWS;
					end
				end
				ST_OWS: begin
					if (c1 == CH_SPACE && c1 != c2) begin
						lane_hold[i] = 1;
						return;
					end
					if (c2 == CH_SPACE && c1 != c2)
						c2 = next_pat(i);
					lane_st[i] = ST_PARAM;
				end
				ST_PARAM: begin
					if (c1 == CH_QUOTE && c1 != c2) begin
						lane_hold[i] = 1;
						return;
					end
					if (c2 == CH_QUOTE && c1 != c2) begin
						c2 = next_pat(i);
						lane_st[i] = ST_QUOT2;
					end
				end
				ST_QUOT1: begin
					if (c1 == CH_QUOTE && c1 != c2) begin
						lane_hold[i] = 1;
						return;
					end
				end
				ST_QUOT2: begin
					if (c2 == CH_QUOTE && c1 != c2) begin
						c2 = next_pat(i);
						lane_st[i] = ST_END;
					end
				end
				default: ;
			endcase
		end
		if (c1 == CH_NUL)
			lane_v[i] = (c2 == CH_NUL) ? V_MATCH : V_MISS;
		else if (c1 != c2)
			lane_v[i] = V_MISS;
	endtask

	task automatic predict_item(item_t it);
		logic hit;
		hit = 0;
		case (it.act)
			ACT_CLEAR: begin
				for (int i = 0; i < NPAT; i++)
					pat_len[i] = 0;
				pat_cnt = 0;
				restart_lanes();
			end
			ACT_APPEND: begin
				restart_lanes();
				if (pat_cnt < NPAT) begin
					if (it.ch == CH_NUL)
						pat_cnt++;
					else if (pat_len[pat_cnt] < PLEN) begin
						pat_mem[pat_cnt][pat_len[pat_cnt]] = it.ch;
						pat_len[pat_cnt]++;
					end
				end
			end
			ACT_RESP: begin
				for (int i = 0; i < pat_cnt; i++)
					step_lane(i, lower(it.ch));
				if (it.ch == CH_NUL) begin
					for (int i = 0; i < pat_cnt; i++)
						if (lane_v[i] == V_MATCH)
							hit = 1;
					restart_lanes();
					expected_hits.push_back(hit);
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	// stimulus helpers
	task automatic push(action_t a, logic [7:0] c);
		item_t it;
		it.act = a;
		it.ch = c;
		pending_items.push_back(it);
	endtask

	task automatic push_str(action_t a, string s, bit close);
		for (int k = 0; k < s.len(); k++)
			push(a, s[k]);
		if (close)
			push(a, CH_NUL);
	endtask

	function automatic string rand_word();
		string w;
		string pool;
		pool = "aAbBtTxX";
		w = "";
		for (int k = $urandom_range(1, 3); k > 0; k--)
			w = {w, string'(pool[$urandom_range(0, 7)])};
		return w;
	endfunction

	function automatic string rand_media();
		string s;
		s = {rand_word(), "/"};
		case ($urandom_range(0, 5))
			0: s = {s, "*"};
			default: s = {s, rand_word()};
		endcase
		case ($urandom_range(0, 5))
			0: s = {s, ";", rand_word(), "=", rand_word()};
			1: s = {s, "; ", rand_word(), "=\"", rand_word(), "\""};
			2: s = {s, " ;", rand_word()};
			default: ;
		endcase
		return s;
	endfunction

	function automatic string mutate(string s);
		string r;
		r = s;
		if (r.len() > 0 && $urandom_range(0, 2) == 0)
			r[$urandom_range(0, r.len() - 1)] = 8'($urandom_range(1, 255));
		if ($urandom_range(0, 3) == 0)
			r = {r, ";", rand_word()};
		if ($urandom_range(0, 4) == 0)
			r = {r, " "};
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// driver
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			action <= ACT_NONE;
			character <= 0;
			send_gap <= 0;
		end else if (in_valid && !in_taken) begin
		end else if (send_gap > 0) begin
			in_valid <= 0;
			send_gap <= send_gap - 1;
		end else if (pending_items.size() > 0 && !sender_done) begin
			item_t it;
			it = pending_items.pop_front();
			in_valid <= 1;
			action <= it.act;
			character <= it.ch;
			send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
		end else begin
			in_valid <= 0;
		end
	end

	// accept and predict at the rising edge
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			item_t it;
			it.act = action_t'(action);
			it.ch = character;
			predict_item(it);
		end
	end

	// receiver
	int recv_gap;
	int rx_cycles;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			recv_gap <= 0;
			rx_cycles <= 0;
		end else begin
			rx_cycles <= rx_cycles + 1;
			if (rx_cycles >= 300 && rx_cycles < 500) begin
				out_ready <= 0;
			end else if (recv_gap > 0) begin
				out_ready <= 0;
				recv_gap <= recv_gap - 1;
			end else if (out_ready && out_valid) begin
				out_ready <= 0;
				recv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0)
				report_mismatch("result with nothing expected");
			else begin
				logic e;
				e = expected_hits.pop_front();
				if (in_list !== e)
					report_mismatch($sformatf("in_list %b expected %b", in_list, e));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		string pats[$];
		errors = 0;
		idle_cycles = 0;
		sender_done = 0;
		pat_cnt = 0;
		for (int i = 0; i < NPAT; i++) begin
			pat_len[i] = 0;
			for (int k = 0; k < PLEN; k++)
				pat_mem[i][k] = 0;
		end
		restart_lanes();
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty list, special patterns, skips, overflow
		push_str(ACT_RESP, "text/html", 1);
		push(ACT_APPEND, CH_NUL);
		push_str(ACT_APPEND, "/", 1);
		push_str(ACT_RESP, "Text/HTML", 1);
		push(ACT_CLEAR, 8'hff);
		push_str(ACT_APPEND, "text/*", 1);
		push_str(ACT_APPEND, "a/b; c=\"d\"", 1);
		push_str(ACT_RESP, "A/B;c=d", 1);
		push_str(ACT_RESP, "a/b ;x", 1);
		push(ACT_NONE, 8'h80);
		push_str(ACT_RESP, "x", 0);
		push(ACT_APPEND, 8'h7f);
		push(ACT_RESP, 8'hff);
		push(ACT_RESP, CH_NUL);
		push(ACT_CLEAR, 0);
		for (int k = 0; k < PLEN + 4; k++)
			push(ACT_APPEND, 8'($urandom_range(1, 255)));
		push(ACT_APPEND, CH_NUL);
		for (int p = 0; p < NPAT + 1; p++)
			push_str(ACT_APPEND, "z/y", 1);
		push_str(ACT_RESP, "z/y", 1);

		// random phases
		while (pending_items.size() < 440) begin
			int n;
			pats.delete();
			push(ACT_CLEAR, 8'($urandom_range(0, 255)));
			n = $urandom_range(0, NPAT);
			for (int p = 0; p < n; p++) begin
				string s;
				s = ($urandom_range(0, 15) == 0) ? "/" : rand_media();
				pats.push_back(s);
				push_str(ACT_APPEND, s, 1);
			end
			for (int r = $urandom_range(2, 6); r > 0; r--) begin
				case ($urandom_range(0, 9))
					0: push(action_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
					1: push_str(ACT_RESP, rand_media(), 1);
					default: begin
						if (pats.size() > 0)
							push_str(ACT_RESP, mutate(pats[$urandom_range(0, pats.size() - 1)]), 1);
						else
							push_str(ACT_RESP, rand_media(), 1);
					end
				endcase
			end
		end

		// sender pause until the output side has drained
		wait (pending_items.size() < 300);
		@(negedge clk);
		sender_done = 1;
		wait (expected_hits.size() == 0 && !in_valid);
		@(negedge clk);
		sender_done = 0;

		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_hits.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/mtlm_pkg.sv
src/mtlm_ram.sv
src/mtlm_cell.sv
src/media_type_list_matcher.sv
tb/tb_media_type_list_matcher.sv
